// File: src/aprel_pkg.sv
package aprel_pkg;

  // One input transaction: the instruction and the two addresses it moves between.
  typedef struct packed {
    logic [63:0] source_address;
    logic [63:0] dest_address;
    logic [31:0] instruction;
  } aprel_in_t;

  // One result transaction: the rewritten word and its status flag.
  typedef struct packed {
    logic [31:0] relocated_word;
    logic        status;
  } aprel_out_t;

  // Immediate layout of the matched instruction form.
  typedef enum logic [2:0] {
    FORM_NONE,
    FORM_IMM26,
    FORM_IMM19,
    FORM_IMM14,
    FORM_ADR,
    FORM_ADRP
  } aprel_form_e;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Opcode masks and match values, listed in decode priority order.
  localparam logic [31:0] MASK_B      = 32'h7C00_0000;
  localparam logic [31:0] MATCH_B     = 32'h1400_0000;
  localparam logic [31:0] MASK_BCOND  = 32'hFF00_0010;
  localparam logic [31:0] MATCH_BCOND = 32'h5400_0000;
  localparam logic [31:0] MASK_CB     = 32'h7E00_0000;
  localparam logic [31:0] MATCH_CB    = 32'h3400_0000;
  localparam logic [31:0] MASK_TB     = 32'h7E00_0000;
  localparam logic [31:0] MATCH_TB    = 32'h3600_0000;
  localparam logic [31:0] MASK_LDR    = 32'hBF00_0000;
  localparam logic [31:0] MATCH_LDR   = 32'h1800_0000;
  localparam logic [31:0] MASK_LDRSW  = 32'hFF00_0000;
  localparam logic [31:0] MATCH_LDRSW = 32'h9800_0000;
  localparam logic [31:0] MASK_LDRFP  = 32'h3F00_0000;
  localparam logic [31:0] MATCH_LDRFP = 32'h1C00_0000;
  localparam logic [31:0] MASK_PRFM   = 32'hFF00_0000;
  localparam logic [31:0] MATCH_PRFM  = 32'hD800_0000;
  localparam logic [31:0] MASK_ADR    = 32'h9F00_0000;
  localparam logic [31:0] MATCH_ADR   = 32'h1000_0000;
  localparam logic [31:0] MATCH_ADRP  = 32'h9000_0000;

endpackage

// File: src/aprel_rewrite.sv
module aprel_rewrite (
  input  aprel_pkg::aprel_in_t  in_data_i,
  output aprel_pkg::aprel_out_t out_data_o
);

  aprel_pkg::aprel_form_e form;
  logic [31:0] insn;
  logic [20:0] imm21;
  logic [63:0] offset;
  logic [63:0] base_src;
  logic [63:0] base_dst;
  logic [63:0] diff;
  logic        fail;
  logic [31:0] word;

  assign insn  = in_data_i.instruction;
  assign imm21 = {insn[23:5], insn[30:29]};

  // Priority decode: the first form whose opcode bits match wins.
  always_comb begin
    priority if ((insn & aprel_pkg::MASK_B) == aprel_pkg::MATCH_B) begin
      form = aprel_pkg::FORM_IMM26;
    end else if ((insn & aprel_pkg::MASK_BCOND) == aprel_pkg::MATCH_BCOND) begin
      form = aprel_pkg::FORM_IMM19;
    end else if ((insn & aprel_pkg::MASK_CB) == aprel_pkg::MATCH_CB) begin
      form = aprel_pkg::FORM_IMM19;
    end else if ((insn & aprel_pkg::MASK_TB) == aprel_pkg::MATCH_TB) begin
      form = aprel_pkg::FORM_IMM14;
    end else if ((insn & aprel_pkg::MASK_LDR) == aprel_pkg::MATCH_LDR) begin
      form = aprel_pkg::FORM_IMM19;
    end else if ((insn & aprel_pkg::MASK_LDRSW) == aprel_pkg::MATCH_LDRSW) begin
      form = aprel_pkg::FORM_IMM19;
    end else if ((insn & aprel_pkg::MASK_LDRFP) == aprel_pkg::MATCH_LDRFP) begin
      form = aprel_pkg::FORM_IMM19;
    end else if ((insn & aprel_pkg::MASK_PRFM) == aprel_pkg::MATCH_PRFM) begin
      form = aprel_pkg::FORM_IMM19;
    end else if ((insn & aprel_pkg::MASK_ADR) == aprel_pkg::MATCH_ADR) begin
      form = aprel_pkg::FORM_ADR;
    end else if ((insn & aprel_pkg::MASK_ADR) == aprel_pkg::MATCH_ADRP) begin
      form = aprel_pkg::FORM_ADRP;
    end else begin
      form = aprel_pkg::FORM_NONE;
    end
  end

  // Sign-extended byte offset of the original target, scaled per form.
  always_comb begin
    unique case (form)
      aprel_pkg::FORM_IMM26: offset = {{36{insn[25]}}, insn[25:0], 2'b00};
      aprel_pkg::FORM_IMM19: offset = {{43{insn[23]}}, insn[23:5], 2'b00};
      aprel_pkg::FORM_IMM14: offset = {{48{insn[18]}}, insn[18:5], 2'b00};
      aprel_pkg::FORM_ADR:   offset = {{43{imm21[20]}}, imm21};
      aprel_pkg::FORM_ADRP:  offset = {{31{imm21[20]}}, imm21, 12'h000};
      default:               offset = '0;
    endcase
  end

  // ADRP works on 4 KiB page bases; all other forms use the full addresses.
  assign base_src = (form == aprel_pkg::FORM_ADRP) ?
                    {in_data_i.source_address[63:12], 12'h000} : in_data_i.source_address;
  assign base_dst = (form == aprel_pkg::FORM_ADRP) ?
                    {in_data_i.dest_address[63:12], 12'h000} : in_data_i.dest_address;

  // New offset as seen from the destination address, wrapping modulo 2^64.
  assign diff = base_src + offset - base_dst;

  // Range and alignment check. A value fits when all bits above the field's sign
  // bit equal it, so the upper slice must be all zeros or all ones.
  always_comb begin
    unique case (form)
      aprel_pkg::FORM_IMM26:
        fail = (diff[1:0] != 2'b00) || !((&diff[63:27]) || !(|diff[63:27]));
      aprel_pkg::FORM_IMM19:
        fail = (diff[1:0] != 2'b00) || !((&diff[63:20]) || !(|diff[63:20]));
      aprel_pkg::FORM_IMM14:
        fail = (diff[1:0] != 2'b00) || !((&diff[63:15]) || !(|diff[63:15]));
      aprel_pkg::FORM_ADR:
        fail = !((&diff[63:20]) || !(|diff[63:20]));
      aprel_pkg::FORM_ADRP:
        fail = !((&diff[63:32]) || !(|diff[63:32]));
      default:
        fail = 1'b0;
    endcase
  end

  // Insert the new immediate; a failed or unmatched word passes unchanged.
  always_comb begin
    word = insn;
    if (!fail) begin
      unique case (form)
        aprel_pkg::FORM_IMM26: word[25:0] = diff[27:2];
        aprel_pkg::FORM_IMM19: word[23:5] = diff[20:2];
        aprel_pkg::FORM_IMM14: word[18:5] = diff[15:2];
        aprel_pkg::FORM_ADR: begin
          word[30:29] = diff[1:0];
          word[23:5]  = diff[20:2];
        end
        aprel_pkg::FORM_ADRP: begin
          word[30:29] = diff[13:12];
          word[23:5]  = diff[32:14];
        end
        default: word = insn;
      endcase
    end
  end

  assign out_data_o.relocated_word = word;
  assign out_data_o.status         = fail ? aprel_pkg::STATUS_FAIL : aprel_pkg::STATUS_OK;

endmodule

// File: src/aarch64_pcrel_insn_relocator.sv
// Channel   Direction  Payload               Handshake
// in        input      aprel_pkg::aprel_in_t   in_valid_i / in_ready_o
// out       output     aprel_pkg::aprel_out_t  out_valid_o / out_ready_i
//
// Each instruction passes through the input register, then the rewrite logic (one
// 64-bit three-operand add and range check) settles into the result register. One
// transaction is accepted every cycle while the output is not stalled.
// Reset clears both valid flags; payload registers are not reset.
// A stall on the output holds both stages; the input register still fills
// while the result waits, so the pipeline holds two transactions.
module aarch64_pcrel_insn_relocator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  aprel_pkg::aprel_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output aprel_pkg::aprel_out_t out_data_o
);

  logic                  in_valid_q;
  aprel_pkg::aprel_in_t  in_data_q;
  logic                  out_valid_q;
  aprel_pkg::aprel_out_t out_data_q;
  aprel_pkg::aprel_out_t result_d;
  logic                  advance;

  // The result register can take a new value when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  aprel_rewrite u_rewrite (
    .in_data_i  (in_data_q),
    .out_data_o (result_d)
  );

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers load only on a moving transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (in_valid_q && advance) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
